@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps

package qrs_pkg;

  // number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_BITS  = 16;

  // square root: root width and even radicand width
  localparam int SQ_BITS   = WORD_BITS + 1;
  localparam int RAD_BITS  = 2 * SQ_BITS;
  localparam int REM_BITS  = SQ_BITS + 2;

  // division: numerator magnitude, denominator magnitude, divisor, dividend
  localparam int NMAG_BITS = WORD_BITS + 2;
  localparam int DMAG_BITS = WORD_BITS + 1;
  localparam int DVS_BITS  = DMAG_BITS + 1;
  localparam int NUM_BITS  = NMAG_BITS + FRAC_BITS + 2;

  // signed widths of numerator and denominator before magnitude
  localparam int NS_BITS   = NMAG_BITS + 1;
  localparam int DS_BITS   = DMAG_BITS + 1;

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  // sideband that rides along the square root cells
  typedef struct packed {
    logic                        valid;
    logic                        a_zero;
    logic                        b_zero;
    logic                        c_zero;
    logic                        d_zero;
    logic                        d_neg;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
    logic signed [WORD_BITS-1:0] c;
  } qrs_side_t;

  // one square root cell's state
  typedef struct packed {
    qrs_side_t           side;
    logic [RAD_BITS-1:0] rad;
    logic [REM_BITS-1:0] rem;
    logic [SQ_BITS-1:0]  root;
  } qrs_sq_t;

  // one division lane
  typedef struct packed {
    logic                 act;
    logic                 neg;
    logic [NUM_BITS-1:0]  num;
    logic [DVS_BITS-1:0]  dvs;
    logic [DVS_BITS-1:0]  rem;
    logic [WORD_BITS-1:0] quo;
    logic                 ovf;
  } qrs_lane_t;

  // one division cell's state, both roots side by side
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
    qrs_lane_t  first;
    qrs_lane_t  second;
  } qrs_div_t;

endpackage

@@ rtl/qrs_sqrt_cell.sv @@
`timescale 1ns / 1ps

module qrs_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  qrs_pkg::qrs_sq_t d_in,
  output qrs_pkg::qrs_sq_t d_out
);

  qrs_pkg::qrs_sq_t cell_r;
  qrs_pkg::qrs_sq_t cell_nxt;

  // one root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [qrs_pkg::REM_BITS:0] r_sh;
    logic [qrs_pkg::REM_BITS:0] trial;
    r_sh  = {d_in.rem[qrs_pkg::REM_BITS-2:0], d_in.rad[qrs_pkg::RAD_BITS-1 -: 2]};
    trial = {1'b0, d_in.root, 2'b01};
    cell_nxt      = d_in;
    cell_nxt.rad  = {d_in.rad[qrs_pkg::RAD_BITS-3:0], 2'b00};
    if (r_sh >= trial) begin
      cell_nxt.rem  = qrs_pkg::REM_BITS'(r_sh - trial);
      cell_nxt.root = {d_in.root[qrs_pkg::SQ_BITS-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = r_sh[qrs_pkg::REM_BITS-1:0];
      cell_nxt.root = {d_in.root[qrs_pkg::SQ_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.side.valid <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

@@ rtl/qrs_div_cell.sv @@
`timescale 1ns / 1ps

module qrs_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  qrs_pkg::qrs_div_t d_in,
  output qrs_pkg::qrs_div_t d_out
);

  qrs_pkg::qrs_div_t cell_r;
  qrs_pkg::qrs_div_t cell_nxt;

  // one restoring quotient bit; bits leaving the top mark overflow
  function automatic qrs_pkg::qrs_lane_t lane_step(qrs_pkg::qrs_lane_t ln);
    logic [qrs_pkg::DVS_BITS:0] r_sh;
    logic                       qb;
    qrs_pkg::qrs_lane_t         res;
    r_sh = {ln.rem, ln.num[qrs_pkg::NUM_BITS-1]};
    qb   = (r_sh >= {1'b0, ln.dvs});
    res      = ln;
    res.num  = {ln.num[qrs_pkg::NUM_BITS-2:0], 1'b0};
    res.rem  = qb ? qrs_pkg::DVS_BITS'(r_sh - {1'b0, ln.dvs})
                  : r_sh[qrs_pkg::DVS_BITS-1:0];
    res.quo  = {ln.quo[qrs_pkg::WORD_BITS-2:0], qb};
    res.ovf  = ln.ovf | ln.quo[qrs_pkg::WORD_BITS-1];
    return res;
  endfunction

  always_comb begin
    cell_nxt        = d_in;
    cell_nxt.first  = lane_step(d_in.first);
    cell_nxt.second = lane_step(d_in.second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

@@ rtl/quadratic_root_solver_unit.sv @@
`timescale 1ns / 1ps
// pipeline: 91 register stages; the accept edge loads the first and the result register is the last
//   (3 front stages, 33 square root cells, 2 setup stages, 52 divide cells, output)
// throughput: one coefficient beat per cycle, busy stays low, results never stall
// reset: synchronous active-low rst_n clears all valid bits and sets the tolerance register tol_r to 0
// configuration is taken at once; write it only with no beat in flight

module quadratic_root_solver_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_a,
  input  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_b,
  input  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_c,
  output logic                                 out_valid,
  output logic [1:0]                           out_root_count,
  output logic signed [qrs_pkg::WORD_BITS-1:0] out_root_first,
  output logic signed [qrs_pkg::WORD_BITS-1:0] out_root_second,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qrs_pkg::TOL_BITS-1:0]         cfg_data
);

  localparam int W = qrs_pkg::WORD_BITS;

  typedef struct packed {
    logic                valid;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [W-1:0] c;
    logic [W-1:0]        ma;
    logic [W-1:0]        mb;
    logic [W-1:0]        mc;
  } mag_t;

  typedef struct packed {
    logic                valid;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [W-1:0] c;
    logic                a_zero;
    logic                b_zero;
    logic                c_zero;
    logic                ac_pos;
    logic [2*W-1:0]      bb;
    logic [2*W-1:0]      ac;
  } prod_t;

  typedef struct packed {
    logic                                 valid;
    logic [1:0]                           count;
    logic                                 act1;
    logic                                 act2;
    logic signed [qrs_pkg::NS_BITS-1:0]   n1;
    logic signed [qrs_pkg::NS_BITS-1:0]   n2;
    logic signed [qrs_pkg::DS_BITS-1:0]   den;
  } setup_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          count;
    logic signed [W-1:0] first;
    logic signed [W-1:0] second;
    logic                sat;
  } res_t;

  logic [qrs_pkg::TOL_BITS-1:0] tol_r;
  mag_t             mag_r,   mag_nxt;
  prod_t            prod_r,  prod_nxt;
  qrs_pkg::qrs_sq_t disc_r,  disc_nxt;
  setup_t           setup_r, setup_nxt;
  qrs_pkg::qrs_div_t div_in_r, div_in_nxt;
  res_t             res_r,   res_nxt;

  qrs_pkg::qrs_sq_t  sq_pipe  [0:qrs_pkg::SQ_BITS];
  qrs_pkg::qrs_div_t div_pipe [0:qrs_pkg::NUM_BITS];

  function automatic logic [W-1:0] mag_of(logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // front: capture and take magnitudes
  always_comb begin
    mag_nxt.valid = start && !busy;
    mag_nxt.a     = in_coef_a;
    mag_nxt.b     = in_coef_b;
    mag_nxt.c     = in_coef_c;
    mag_nxt.ma    = mag_of(in_coef_a);
    mag_nxt.mb    = mag_of(in_coef_b);
    mag_nxt.mc    = mag_of(in_coef_c);
  end

  // products and near-zero tests
  always_comb begin
    prod_nxt.valid  = mag_r.valid;
    prod_nxt.a      = mag_r.a;
    prod_nxt.b      = mag_r.b;
    prod_nxt.c      = mag_r.c;
    prod_nxt.a_zero = mag_r.ma <= W'(tol_r);
    prod_nxt.b_zero = mag_r.mb <= W'(tol_r);
    prod_nxt.c_zero = mag_r.mc <= W'(tol_r);
    prod_nxt.ac_pos = (mag_r.c != '0) && (mag_r.a[W-1] == mag_r.c[W-1]);
    prod_nxt.bb     = mag_r.mb * mag_r.mb;
    prod_nxt.ac     = mag_r.ma * mag_r.mc;
  end

  // discriminant magnitude and sign, tolerance test
  always_comb begin
    logic [qrs_pkg::RAD_BITS-1:0] bb_x;
    logic [qrs_pkg::RAD_BITS-1:0] ac4_x;
    logic [qrs_pkg::RAD_BITS-1:0] dm;
    logic [qrs_pkg::RAD_BITS-1:0] tol_x;
    logic                         d_neg;
    bb_x  = qrs_pkg::RAD_BITS'(prod_r.bb);
    ac4_x = qrs_pkg::RAD_BITS'({prod_r.ac, 2'b00});
    tol_x = qrs_pkg::RAD_BITS'({tol_r, {qrs_pkg::FRAC_BITS{1'b0}}});
    d_neg = 1'b0;
    if (!prod_r.ac_pos) begin
      dm = bb_x + ac4_x;
    end else if (bb_x >= ac4_x) begin
      dm = bb_x - ac4_x;
    end else begin
      dm    = ac4_x - bb_x;
      d_neg = 1'b1;
    end
    disc_nxt.side.valid  = prod_r.valid;
    disc_nxt.side.a_zero = prod_r.a_zero;
    disc_nxt.side.b_zero = prod_r.b_zero;
    disc_nxt.side.c_zero = prod_r.c_zero;
    disc_nxt.side.d_zero = dm <= tol_x;
    disc_nxt.side.d_neg  = d_neg;
    disc_nxt.side.a      = prod_r.a;
    disc_nxt.side.b      = prod_r.b;
    disc_nxt.side.c      = prod_r.c;
    disc_nxt.rad         = dm;
    disc_nxt.rem         = '0;
    disc_nxt.root        = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r.valid       <= 1'b0;
      prod_r.valid      <= 1'b0;
      disc_r.side.valid <= 1'b0;
    end else begin
      mag_r  <= mag_nxt;
      prod_r <= prod_nxt;
      disc_r <= disc_nxt;
    end
  end

  // square root chain, one root bit per cell
  assign sq_pipe[0] = disc_r;

  for (genvar i = 0; i < qrs_pkg::SQ_BITS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (sq_pipe[i]),
      .d_out (sq_pipe[i+1])
    );
  end

  // rounding of the root and choice of case
  always_comb begin
    qrs_pkg::qrs_sq_t                   sq;
    logic [qrs_pkg::SQ_BITS-1:0]        s;
    logic signed [qrs_pkg::NS_BITS-1:0] nb;
    logic signed [qrs_pkg::NS_BITS-1:0] nc;
    logic signed [qrs_pkg::NS_BITS-1:0] s_x;
    logic signed [qrs_pkg::DS_BITS-1:0] two_a;
    logic signed [qrs_pkg::DS_BITS-1:0] b_x;
    sq    = sq_pipe[qrs_pkg::SQ_BITS];
    s     = sq.root + qrs_pkg::SQ_BITS'(sq.rem > qrs_pkg::REM_BITS'(sq.root));
    nb    = -{{(qrs_pkg::NS_BITS-W){sq.side.b[W-1]}}, sq.side.b};
    nc    = -{{(qrs_pkg::NS_BITS-W){sq.side.c[W-1]}}, sq.side.c};
    s_x   = {{(qrs_pkg::NS_BITS-qrs_pkg::SQ_BITS){1'b0}}, s};
    two_a = {{(qrs_pkg::DS_BITS-W-1){sq.side.a[W-1]}}, sq.side.a, 1'b0};
    b_x   = {{(qrs_pkg::DS_BITS-W){sq.side.b[W-1]}}, sq.side.b};
    setup_nxt.valid = sq.side.valid;
    setup_nxt.count = qrs_pkg::CNT_NONE;
    setup_nxt.act1  = 1'b0;
    setup_nxt.act2  = 1'b0;
    setup_nxt.n1    = nb;
    setup_nxt.n2    = nb;
    setup_nxt.den   = two_a;
    if (sq.side.a_zero) begin
      if (sq.side.b_zero) begin
        setup_nxt.count = sq.side.c_zero ? qrs_pkg::CNT_ALL : qrs_pkg::CNT_NONE;
      end else begin
        setup_nxt.count = qrs_pkg::CNT_ONE;
        setup_nxt.act1  = 1'b1;
        setup_nxt.n1    = nc;
        setup_nxt.den   = b_x;
      end
    end else if (sq.side.d_zero) begin
      setup_nxt.count = qrs_pkg::CNT_ONE;
      setup_nxt.act1  = 1'b1;
    end else if (!sq.side.d_neg) begin
      setup_nxt.count = qrs_pkg::CNT_TWO;
      setup_nxt.act1  = 1'b1;
      setup_nxt.act2  = 1'b1;
      setup_nxt.n1    = nb + s_x;
      setup_nxt.n2    = nb - s_x;
    end
  end

  // magnitudes, signs and scaled dividends for both lanes
  always_comb begin
    logic [qrs_pkg::NMAG_BITS-1:0] m1;
    logic [qrs_pkg::NMAG_BITS-1:0] m2;
    logic [qrs_pkg::DMAG_BITS-1:0] md;
    logic [qrs_pkg::NUM_BITS-1:0]  md_x;
    m1 = setup_r.n1[qrs_pkg::NS_BITS-1] ? qrs_pkg::NMAG_BITS'(-setup_r.n1)
                                        : qrs_pkg::NMAG_BITS'(setup_r.n1);
    m2 = setup_r.n2[qrs_pkg::NS_BITS-1] ? qrs_pkg::NMAG_BITS'(-setup_r.n2)
                                        : qrs_pkg::NMAG_BITS'(setup_r.n2);
    md = setup_r.den[qrs_pkg::DS_BITS-1] ? qrs_pkg::DMAG_BITS'(-setup_r.den)
                                         : qrs_pkg::DMAG_BITS'(setup_r.den);
    md_x = qrs_pkg::NUM_BITS'(md);
    div_in_nxt.valid      = setup_r.valid;
    div_in_nxt.count      = setup_r.count;
    div_in_nxt.first.act  = setup_r.act1;
    div_in_nxt.first.neg  = setup_r.n1[qrs_pkg::NS_BITS-1] ^ setup_r.den[qrs_pkg::DS_BITS-1];
    div_in_nxt.first.num  = {1'b0, m1, {(qrs_pkg::FRAC_BITS+1){1'b0}}} + md_x;
    div_in_nxt.first.dvs  = {md, 1'b0};
    div_in_nxt.first.rem  = '0;
    div_in_nxt.first.quo  = '0;
    div_in_nxt.first.ovf  = 1'b0;
    div_in_nxt.second     = div_in_nxt.first;
    div_in_nxt.second.act = setup_r.act2;
    div_in_nxt.second.neg = setup_r.n2[qrs_pkg::NS_BITS-1] ^ setup_r.den[qrs_pkg::DS_BITS-1];
    div_in_nxt.second.num = {1'b0, m2, {(qrs_pkg::FRAC_BITS+1){1'b0}}} + md_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r.valid  <= 1'b0;
      div_in_r.valid <= 1'b0;
    end else begin
      setup_r  <= setup_nxt;
      div_in_r <= div_in_nxt;
    end
  end

  // division chain, one quotient bit per cell
  assign div_pipe[0] = div_in_r;

  for (genvar j = 0; j < qrs_pkg::NUM_BITS; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (div_pipe[j]),
      .d_out (div_pipe[j+1])
    );
  end

  // clamp, sign and zero the unused roots
  always_comb begin
    qrs_pkg::qrs_div_t dv;
    logic [W-1:0]      lim1;
    logic [W-1:0]      lim2;
    logic [W-1:0]      v1;
    logic [W-1:0]      v2;
    logic              o1;
    logic              o2;
    dv   = div_pipe[qrs_pkg::NUM_BITS];
    lim1 = dv.first.neg  ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    lim2 = dv.second.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    o1   = dv.first.ovf  || (dv.first.quo > lim1);
    o2   = dv.second.ovf || (dv.second.quo > lim2);
    v1   = o1 ? lim1 : dv.first.quo;
    v2   = o2 ? lim2 : dv.second.quo;
    res_nxt.valid  = dv.valid;
    res_nxt.count  = dv.count;
    res_nxt.first  = !dv.first.act  ? '0 : (dv.first.neg  ? -v1 : v1);
    res_nxt.second = !dv.second.act ? '0 : (dv.second.neg ? -v2 : v2);
    res_nxt.sat    = (dv.first.act && o1) || (dv.second.act && o2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_r.valid;
  assign out_root_count  = res_r.count;
  assign out_root_first  = res_r.first;
  assign out_root_second = res_r.second;
  assign out_saturated   = res_r.sat;

endmodule

@@ rtl/qrs_checker.sv @@
`timescale 1ns / 1ps

module qrs_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic [1:0]                           out_root_count,
  input logic signed [qrs_pkg::WORD_BITS-1:0] out_root_first,
  input logic signed [qrs_pkg::WORD_BITS-1:0] out_root_second,
  input logic                                 out_saturated
);

  // no beat comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // no roots or every number: root fields and flag are clear
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_root_count == qrs_pkg::CNT_NONE ||
                   out_root_count == qrs_pkg::CNT_ALL))
    |-> (out_root_first == '0 && out_root_second == '0 && !out_saturated))
    else $error("root fields set with no finite root");

  // single root leaves the second field clear
  a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_root_count == qrs_pkg::CNT_ONE) |-> out_root_second == '0)
    else $error("second root set for a single root");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_root_count  (out_root_count),
  .out_root_first  (out_root_first),
  .out_root_second (out_root_second),
  .out_saturated   (out_saturated)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 91;

  typedef struct {
    logic signed [qrs_pkg::WORD_BITS-1:0] a;
    logic signed [qrs_pkg::WORD_BITS-1:0] b;
    logic signed [qrs_pkg::WORD_BITS-1:0] c;
  } coef_t;

  typedef struct {
    logic [1:0]                           count;
    logic signed [qrs_pkg::WORD_BITS-1:0] first;
    logic signed [qrs_pkg::WORD_BITS-1:0] second;
    logic                                 sat;
  } roots_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_a;
  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_b;
  logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_c;
  logic                                 out_valid;
  logic [1:0]                           out_root_count;
  logic signed [qrs_pkg::WORD_BITS-1:0] out_root_first;
  logic signed [qrs_pkg::WORD_BITS-1:0] out_root_second;
  logic                                 out_saturated;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [qrs_pkg::TOL_BITS-1:0]         cfg_data;

  quadratic_root_solver_unit u_top (.*);

  coef_t  pending_eqs[$];
  roots_t expected_roots[$];
  logic [qrs_pkg::TOL_BITS-1:0] tolerance;
  int errors;
  int solved;
  int gap;
  int eq_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] mag128(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // round(n * 2^FRAC / d), ties away from zero, clamped to the word range
  function automatic logic signed [qrs_pkg::WORD_BITS-1:0] rounded_quotient(
      input logic signed [127:0] n, input logic signed [127:0] d, inout logic sat);
    logic neg;
    logic [127:0] q;
    logic [127:0] lim;
    neg = (n < 0) != (d < 0);
    q = ((mag128(n) << (qrs_pkg::FRAC_BITS + 1)) + mag128(d)) / (mag128(d) << 1);
    lim = neg ? (128'd1 << (qrs_pkg::WORD_BITS - 1))
              : (128'd1 << (qrs_pkg::WORD_BITS - 1)) - 1;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[qrs_pkg::WORD_BITS-1:0] : q[qrs_pkg::WORD_BITS-1:0];
  endfunction

  function automatic logic [127:0] rounded_sqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic roots_t solve_quadratic(input coef_t e,
                                             input logic [qrs_pkg::TOL_BITS-1:0] tol);
    roots_t r;
    logic signed [127:0] a, b, c, d, s;
    a = e.a;
    b = e.b;
    c = e.c;
    r = '{count: qrs_pkg::CNT_NONE, first: '0, second: '0, sat: 1'b0};
    if (mag128(a) <= tol) begin
      if (mag128(b) <= tol) begin
        r.count = (mag128(c) <= tol) ? qrs_pkg::CNT_ALL : qrs_pkg::CNT_NONE;
      end else begin
        r.first = rounded_quotient(-c, b, r.sat);
        r.count = qrs_pkg::CNT_ONE;
      end
    end else begin
      d = b * b - 4 * a * c;
      if (mag128(d) <= (128'(tol) << qrs_pkg::FRAC_BITS)) begin
        r.first = rounded_quotient(-b, 2 * a, r.sat);
        r.count = qrs_pkg::CNT_ONE;
      end else if (d > 0) begin
        s = rounded_sqrt(d);
        r.first  = rounded_quotient(-b + s, 2 * a, r.sat);
        r.second = rounded_quotient(-b - s, 2 * a, r.sat);
        r.count = qrs_pkg::CNT_TWO;
      end
    end
    return r;
  endfunction

  function automatic logic [qrs_pkg::WORD_BITS-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed(16'($urandom)) <<< qrs_pkg::FRAC_BITS;
      2: return $signed(qrs_pkg::WORD_BITS'($signed(8'($urandom)))) <<< $urandom_range(0, 20);
      3: return $urandom_range(0, 8) - 4;
      4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed(24'($urandom));
    endcase
  endfunction

  // queue equations, including ones built with an exact double root
  task automatic add_random(input int n);
    coef_t e;
    logic signed [qrs_pkg::WORD_BITS-1:0] k, m;
    repeat (n) begin
      e.a = rand_coef();
      e.b = rand_coef();
      e.c = rand_coef();
      if ($urandom_range(0, 5) == 0) begin
        k = $signed(8'($urandom));
        m = $signed(8'($urandom));
        e.a = k * k;
        e.b = 2 * k * m;
        e.c = m * m;
      end
      pending_eqs.push_back(e);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      expected_roots.push_back(solve_quadratic(
          '{a: in_coef_a, b: in_coef_b, c: in_coef_c}, tolerance));
      eq_count <= eq_count + 1;
      if (pending_eqs.size() > 0 && $urandom_range(0, 2) == 0) begin
        coef_t e;
        e = pending_eqs.pop_front();
        in_coef_a <= e.a;
        in_coef_b <= e.b;
        in_coef_c <= e.c;
      end else begin
        start <= 1'b0;
        gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
    end else if (!start && gap > 0) begin
      gap <= gap - 1;
    end else if (!start && pending_eqs.size() > 0) begin
      coef_t e;
      e = pending_eqs.pop_front();
      in_coef_a <= e.a;
      in_coef_b <= e.b;
      in_coef_c <= e.c;
      start <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result beat count=%0d", $time, out_root_count);
        errors++;
      end else begin
        roots_t x;
        x = expected_roots.pop_front();
        solved++;
        if (x.count !== out_root_count) begin
          $display("%0t: root_count expected %0d actual %0d", $time, x.count, out_root_count);
          errors++;
        end
        if (x.first !== out_root_first) begin
          $display("%0t: root_first expected %0d actual %0d", $time, x.first, out_root_first);
          errors++;
        end
        if (x.second !== out_root_second) begin
          $display("%0t: root_second expected %0d actual %0d", $time, x.second,
                   out_root_second);
          errors++;
        end
        if (x.sat !== out_saturated) begin
          $display("%0t: saturated expected %0d actual %0d", $time, x.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  task automatic write_tolerance(input logic [qrs_pkg::TOL_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tolerance = v;
    cfg_valid <= 1'b0;
  endtask

  // sample between edges so the driver's updates have settled
  task automatic drain();
    while (pending_eqs.size() > 0 || start || expected_roots.size() > 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [qrs_pkg::TOL_BITS-1:0] tol_set[5];
    tol_set = '{16'd0, 16'hffff, 16'd3, 16'd100, 16'd0};
    rst_n = 1'b0;
    start = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tolerance = '0;
    errors = 0;
    solved = 0;
    eq_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: linear, all-numbers, no solution, double root, complex, extremes
    pending_eqs.push_back('{0, 0, 0});
    pending_eqs.push_back('{0, 0, 32'h0001_0000});
    pending_eqs.push_back('{0, 32'h0002_0000, 32'hfffc_0000});
    pending_eqs.push_back('{0, 1, 32'h7fff_ffff});
    pending_eqs.push_back('{0, 1, 32'h8000_0000});
    pending_eqs.push_back('{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000});
    pending_eqs.push_back('{32'h0001_0000, 0, 32'h0001_0000});
    pending_eqs.push_back('{32'h0001_0000, 0, 32'hfffc_0000});
    pending_eqs.push_back('{32'h0001_0000, 32'h0003_0000, 0});
    pending_eqs.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
    pending_eqs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff});
    pending_eqs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_eqs.push_back('{1, 32'h7fff_ffff, 32'h8000_0000});
    pending_eqs.push_back('{-1, 32'h8000_0000, 1});
    pending_eqs.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    pending_eqs.push_back('{3, 5, 2});
    drain();
    foreach (tol_set[i]) begin
      write_tolerance(tol_set[i]);
      if (i == 1) begin
        pending_eqs.push_back('{32'h0000_ffff, 32'hffff_0001, 32'h0000_ffff});
        pending_eqs.push_back('{32'h0001_0000, 32'h0000_ffff, 32'h0001_0000});
      end
      add_random(180);
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d equations and checked %0d results over six tolerance phases",
             eq_count, solved);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
